>>> src/assert_macros.svh
// Assertion macros for the block table; clocked on clk, disabled while rst_n is low.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ARBT_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ARBT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ARBT_ASSERT(lbl, expr, msg)
`define ARBT_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

>>> src/arbt_pkg.sv
// Shared types, codes and defaults of the address range block table.
// No dependencies.
package arbt_pkg;

    localparam int TABLE_SLOTS_DEF  = 16;
    localparam int ADDRESS_BITS_DEF = 48;
    localparam int START_BITS       = 48;
    localparam int LEN_BITS         = 31;
    localparam int AMOUNT_BITS      = 32;
    localparam int SLOT_ID_BITS     = 4;

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_FIND   = 3'd1;
    localparam logic [2:0] OP_RESIZE = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_LENGTH = 3'd4;
    localparam logic [2:0] OP_SLOT   = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NEG_SIZE  = 2'd3;

    typedef logic [2:0] action_t;

    localparam action_t A_HOLD  = 3'd0;
    localparam action_t A_NEW   = 3'd1;
    localparam action_t A_LEFT  = 3'd2;
    localparam action_t A_RIGHT = 3'd3;
    localparam action_t A_LEN   = 3'd4;

    typedef struct packed {
        logic eq;
        logic gt;
        logic hit;
        logic sel;
    } cell_flags_t;

    typedef struct packed {
        logic [2:0]                    opcode;
        logic [START_BITS-1:0]         address;
        logic signed [AMOUNT_BITS-1:0] amount;
        logic [SLOT_ID_BITS-1:0]       slot_select;
    } req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [SLOT_ID_BITS-1:0] slot_id;
        logic [START_BITS-1:0]   block_start;
        logic [LEN_BITS-1:0]     block_length;
    } rsp_t;

endpackage

>>> src/arbt_stream_if.sv
// Valid/ready channel carrying one word of a given payload type.
// Payload types come from arbt_pkg.
interface arbt_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/arbt_cell.sv
// One position of the sorted block row: entry registers and registered compare flags.
// Depends on arbt_pkg.
module arbt_cell #(
    parameter int SW = 4,
    parameter int AW = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  arbt_pkg::action_t                 action,
    input  logic [AW-1:0]                     probe_addr,
    input  logic [arbt_pkg::SLOT_ID_BITS-1:0] probe_sel,
    input  logic [SW-1:0]                     new_slot,
    input  logic [AW-1:0]                     new_start,
    input  logic [arbt_pkg::LEN_BITS-1:0]     new_length,
    input  logic                              left_valid,
    input  logic [SW-1:0]                     left_slot,
    input  logic [AW-1:0]                     left_start,
    input  logic [arbt_pkg::LEN_BITS-1:0]     left_length,
    input  logic                              right_valid,
    input  logic [SW-1:0]                     right_slot,
    input  logic [AW-1:0]                     right_start,
    input  logic [arbt_pkg::LEN_BITS-1:0]     right_length,
    output logic                              valid,
    output logic [SW-1:0]                     slot,
    output logic [AW-1:0]                     start,
    output logic [arbt_pkg::LEN_BITS-1:0]     length,
    output arbt_pkg::cell_flags_t             flags
);
    import arbt_pkg::*;

    localparam int CW   = (AW > LEN_BITS) ? AW : LEN_BITS;
    localparam int SELW = (SW > SLOT_ID_BITS) ? SW : SLOT_ID_BITS;

    logic                valid_reg, valid_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic [AW-1:0]       start_reg, start_next;
    logic [LEN_BITS-1:0] length_reg, length_next;
    cell_flags_t         flags_reg, flags_next;

    logic [AW:0]   diff;
    logic [CW-1:0] offset_ext;
    logic [CW-1:0] length_ext;

    always_comb
    begin
        valid_next  = valid_reg;
        slot_next   = slot_reg;
        start_next  = start_reg;
        length_next = length_reg;
        unique case (action)
            A_HOLD:
            begin
            end
            A_NEW:
            begin
                valid_next  = 1'b1;
                slot_next   = new_slot;
                start_next  = new_start;
                length_next = new_length;
            end
            A_LEFT:
            begin
                valid_next  = left_valid;
                slot_next   = left_slot;
                start_next  = left_start;
                length_next = left_length;
            end
            A_RIGHT:
            begin
                valid_next  = right_valid;
                slot_next   = right_slot;
                start_next  = right_start;
                length_next = right_length;
            end
            A_LEN:
            begin
                length_next = new_length;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        diff       = {1'b0, probe_addr} - {1'b0, start_reg};
        offset_ext = CW'(diff[AW-1:0]);
        length_ext = CW'(length_reg);
        flags_next.eq  = valid_reg && (start_reg == probe_addr);
        flags_next.gt  = !valid_reg || diff[AW];
        flags_next.hit = valid_reg && !diff[AW] && (offset_ext < length_ext);
        flags_next.sel = valid_reg && (SELW'(slot_reg) == SELW'(probe_sel));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        start_reg  <= start_next;
        length_reg <= length_next;
        flags_reg  <= flags_next;
    end

    assign valid  = valid_reg;
    assign slot   = slot_reg;
    assign start  = start_reg;
    assign length = length_reg;
    assign flags  = flags_reg;

endmodule

>>> src/address_range_block_table_top.sv
// Top level of the address range block table: control, free-slot map and the row of cells.
// Depends on arbt_pkg, arbt_stream_if, arbt_cell and assert_macros.svh.
//
//  channel | dir | modport | word
//  req     | in  | sink    | opcode, address, amount, slot_select
//  rsp     | out | source  | status, slot_id, block_start, block_length
//
// Each request word passes through a compare state, in which every cell checks the
// probe against its entry, and then an apply state, in which the first matching
// cell is selected and the row shifts or updates. A new word is taken in the apply
// state, so words follow back to back while rsp drains. A stalled rsp holds the
// apply state. Reset empties the row at once; there is no clearing pass.
`include "assert_macros.svh"

module address_range_block_table_top #(
    parameter int TABLE_SLOTS  = arbt_pkg::TABLE_SLOTS_DEF,
    parameter int ADDRESS_BITS = arbt_pkg::ADDRESS_BITS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    arbt_stream_if.sink   req,
    arbt_stream_if.source rsp
);
    import arbt_pkg::*;

    localparam int N    = TABLE_SLOTS;
    localparam int SW   = $clog2(N);
    localparam int AW   = (ADDRESS_BITS < START_BITS) ? ADDRESS_BITS : START_BITS;
    localparam int SELW = (SW > SLOT_ID_BITS) ? SW : SLOT_ID_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_ACT  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [2:0]             op_reg;
    logic [AW-1:0]          addr_reg;
    logic [AMOUNT_BITS-1:0] amount_reg;
    logic [SLOT_ID_BITS-1:0] sel_reg;
    logic [SW-1:0]          free_slot_reg, free_slot_next;
    logic                   no_free_reg;
    logic [N-1:0]           slot_used_reg, slot_used_next;
    rsp_t                   rsp_reg, rsp_next;
    logic                   rsp_valid_reg;

    logic          accept;
    logic          commit;
    logic [N-1:0]  free_onehot;

    logic [N-1:0]        cell_valid;
    logic [SW-1:0]       cell_slot   [N];
    logic [AW-1:0]       cell_start  [N];
    logic [LEN_BITS-1:0] cell_len    [N];
    cell_flags_t         cell_flags  [N];
    action_t             cell_action [N];

    logic [N-1:0] eqv, gtv, hitv, selv, ins_cond;
    logic [N-1:0] eq_first, hit_first, pick, del_mask;
    logic [SW-1:0]       pick_slot;
    logic [AW-1:0]       pick_start;
    logic [LEN_BITS-1:0] pick_len;
    logic [SELW-1:0]     pick_slot_ext, free_slot_ext;
    logic [32:0]         len_sum;
    logic [LEN_BITS-1:0] sat_len;
    logic [LEN_BITS-1:0] new_len;

    // handshake and sequencing
    assign commit = (state_reg == S_ACT) && (!rsp_valid_reg || rsp.ready);
    assign req.ready = (state_reg == S_IDLE) || commit;
    assign accept = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_CMP : S_IDLE;
            S_CMP:   state_next = S_ACT;
            S_ACT:   state_next = commit ? (accept ? S_CMP : S_IDLE) : S_ACT;
            default: state_next = S_IDLE;
        endcase
    end

    // lowest free slot
    always_comb
    begin
        free_onehot    = ~slot_used_reg & (slot_used_reg + 1'b1);
        free_slot_next = '0;
        for (int i = 0; i < N; i++)
        begin
            if (free_onehot[i])
            begin
                free_slot_next = free_slot_next | SW'(i);
            end
        end
    end

    // first-match selection over the row, slot match for OP_SLOT, and the new length
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            eqv[i]      = cell_flags[i].eq;
            gtv[i]      = cell_flags[i].gt;
            hitv[i]     = cell_flags[i].hit;
            selv[i]     = cell_flags[i].sel;
            ins_cond[i] = gtv[i] || (eqv[i] && (cell_slot[i] > free_slot_reg));
        end
        eq_first  = eqv & (~eqv + 1'b1);
        hit_first = hitv & (~hitv + 1'b1);
        del_mask  = (|eqv) ? ~(eq_first - 1'b1) : '0;
        if (op_reg == OP_FIND)
        begin
            pick = hit_first;
        end
        else if (op_reg == OP_SLOT)
        begin
            pick = selv;
        end
        else
        begin
            pick = eq_first;
        end
        pick_slot  = '0;
        pick_start = '0;
        pick_len   = '0;
        for (int i = 0; i < N; i++)
        begin
            if (pick[i])
            begin
                pick_slot  = pick_slot | cell_slot[i];
                pick_start = pick_start | cell_start[i];
                pick_len   = pick_len | cell_len[i];
            end
        end
        pick_slot_ext = SELW'(pick_slot);
        free_slot_ext = SELW'(free_slot_reg);
        len_sum = {2'b00, pick_len} + {amount_reg[AMOUNT_BITS-1], amount_reg};
        if (len_sum[32])
        begin
            sat_len = '0;
        end
        else if (len_sum[31])
        begin
            sat_len = '1;
        end
        else
        begin
            sat_len = len_sum[LEN_BITS-1:0];
        end
        new_len = (op_reg == OP_RESIZE) ? sat_len : amount_reg[LEN_BITS-1:0];
    end

    // apply step
    always_comb
    begin
        rsp_next        = '0;
        rsp_next.status = ST_NOT_FOUND;
        slot_used_next  = slot_used_reg;
        for (int i = 0; i < N; i++)
        begin
            cell_action[i] = A_HOLD;
        end
        if (commit)
        begin
            unique case (op_reg)
                OP_APPEND:
                begin
                    if (amount_reg[AMOUNT_BITS-1])
                    begin
                        rsp_next.status = ST_NEG_SIZE;
                    end
                    else if (no_free_reg || cell_valid[N-1])
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        for (int i = 0; i < N; i++)
                        begin
                            if (i > 0 && ins_cond[i-1])
                            begin
                                cell_action[i] = A_LEFT;
                            end
                            else if (ins_cond[i])
                            begin
                                cell_action[i] = A_NEW;
                            end
                        end
                        slot_used_next[free_slot_reg] = 1'b1;
                        rsp_next.status       = ST_OK;
                        rsp_next.slot_id      = free_slot_ext[SLOT_ID_BITS-1:0];
                        rsp_next.block_start  = START_BITS'(addr_reg);
                        rsp_next.block_length = amount_reg[LEN_BITS-1:0];
                    end
                end
                OP_FIND, OP_LENGTH, OP_SLOT:
                begin
                    if (|pick)
                    begin
                        rsp_next.status       = ST_OK;
                        rsp_next.slot_id      = pick_slot_ext[SLOT_ID_BITS-1:0];
                        rsp_next.block_start  = START_BITS'(pick_start);
                        rsp_next.block_length = pick_len;
                    end
                end
                OP_RESIZE:
                begin
                    if (|pick)
                    begin
                        for (int i = 0; i < N; i++)
                        begin
                            if (pick[i])
                            begin
                                cell_action[i] = A_LEN;
                            end
                        end
                        rsp_next.status       = ST_OK;
                        rsp_next.slot_id      = pick_slot_ext[SLOT_ID_BITS-1:0];
                        rsp_next.block_start  = START_BITS'(pick_start);
                        rsp_next.block_length = sat_len;
                    end
                end
                OP_DELETE:
                begin
                    if (|pick)
                    begin
                        for (int i = 0; i < N; i++)
                        begin
                            if (del_mask[i])
                            begin
                                cell_action[i] = A_RIGHT;
                            end
                        end
                        slot_used_next[pick_slot] = 1'b0;
                        rsp_next.status       = ST_OK;
                        rsp_next.slot_id      = pick_slot_ext[SLOT_ID_BITS-1:0];
                        rsp_next.block_start  = START_BITS'(pick_start);
                        rsp_next.block_length = pick_len;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_used_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_used_reg <= slot_used_next;
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= req.payload.opcode;
            addr_reg   <= req.payload.address[AW-1:0];
            amount_reg <= req.payload.amount;
            sel_reg    <= req.payload.slot_select;
        end
        if (commit)
        begin
            rsp_reg <= rsp_next;
        end
        free_slot_reg <= free_slot_next;
        no_free_reg   <= &slot_used_reg;
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    // row of cells, kept packed towards position 0 in ascending (start, slot) order
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        logic                lv, rv;
        logic [SW-1:0]       ls, rs;
        logic [AW-1:0]       lst, rst;
        logic [LEN_BITS-1:0] ll, rl;

        if (g == 0)
        begin : g_left_edge
            assign lv  = 1'b0;
            assign ls  = '0;
            assign lst = '0;
            assign ll  = '0;
        end
        else
        begin : g_left
            assign lv  = cell_valid[g-1];
            assign ls  = cell_slot[g-1];
            assign lst = cell_start[g-1];
            assign ll  = cell_len[g-1];
        end

        if (g == N - 1)
        begin : g_right_edge
            assign rv  = 1'b0;
            assign rs  = '0;
            assign rst = '0;
            assign rl  = '0;
        end
        else
        begin : g_right
            assign rv  = cell_valid[g+1];
            assign rs  = cell_slot[g+1];
            assign rst = cell_start[g+1];
            assign rl  = cell_len[g+1];
        end

        arbt_cell #(
            .SW (SW),
            .AW (AW)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .action       (cell_action[g]),
            .probe_addr   (addr_reg),
            .probe_sel    (sel_reg),
            .new_slot     (free_slot_reg),
            .new_start    (addr_reg),
            .new_length   (new_len),
            .left_valid   (lv),
            .left_slot    (ls),
            .left_start   (lst),
            .left_length  (ll),
            .right_valid  (rv),
            .right_slot   (rs),
            .right_start  (rst),
            .right_length (rl),
            .valid        (cell_valid[g]),
            .slot         (cell_slot[g]),
            .start        (cell_start[g]),
            .length       (cell_len[g]),
            .flags        (cell_flags[g])
        );
    end

    `ARBT_ASSERT(a_row_packed, (cell_valid & (cell_valid + 1'b1)) == '0, "row has a gap")
    `ARBT_ASSERT(a_map_matches_row,
        $countones(cell_valid) == $countones(slot_used_reg), "slot map and row disagree")
    `ARBT_ASSERT_IMP(a_act_follows_cmp, state_reg == S_ACT,
        $past(state_reg) == S_CMP || $past(state_reg) == S_ACT, "apply without compare")
    `ARBT_ASSERT_IMP(a_fail_is_zero, rsp_valid_reg && rsp_reg.status != ST_OK,
        rsp_reg.slot_id == '0 && rsp_reg.block_start == '0 && rsp_reg.block_length == '0,
        "failed word carries data")

endmodule
